// ===== rtl/core/mcst_pkg.sv =====
// Shared types, constants and the quarter-wave sine table of the multichannel
// sine test generator. No dependencies; every other file of the block but mcst_ram imports it.
package mcst_pkg;

  // Channel bank and phase resolution.
  localparam int CHANNELS    = 6;
  localparam int NREG_CH     = 6;
  localparam int ACTIVE_MAX  = (CHANNELS < NREG_CH) ? CHANNELS : NREG_CH;
  localparam int CH_W        = (ACTIVE_MAX > 1) ? $clog2(ACTIVE_MAX) : 1;
  localparam int PHASE_BITS  = 12;
  localparam int QUARTER     = 1 << (PHASE_BITS - 2);
  localparam int ROM_AW      = PHASE_BITS - 1;

  // Field widths.
  localparam int SR_W        = 16;
  localparam int FREQ_W      = 15;
  localparam int MODE_W      = 2;
  localparam int CNT_W       = 3;
  localparam int SAMPLE_W    = 22;
  localparam int IDX_W       = 16;
  localparam int PROD_W      = IDX_W + FREQ_W;
  localparam int WRAP_W      = PROD_W + 1;
  localparam int REG_W       = 3;
  localparam int CFG_DATA_W  = 16;

  // Phase divider: dividend is index*freq*2^(PHASE_BITS+1) + rate, divisor is 2*rate.
  localparam int DSR_W       = SR_W + 1;
  localparam int DVD_RAW_W   = PROD_W + PHASE_BITS + 2;
  localparam int DIV_BITS    = 4;
  localparam int DIV_STEPS   = (DVD_RAW_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DVD_W       = DIV_STEPS * DIV_BITS;
  localparam int DIV_CNT_W   = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  // Sine table and amplitude.
  localparam int SINE_W      = 31;
  localparam int AMP_W       = 15;
  localparam int MAG_W       = 15;
  localparam int Q_SHIFT     = 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1 << Q_SHIFT;
  localparam logic [AMP_W-1:0] AMP_FULL   = 15'd32767;
  localparam logic [AMP_W-1:0] AMP_HALF   = 15'd16382;
  localparam logic [AMP_W-1:0] AMP_SCALED = 15'd32766;
  localparam int SCALE_SHIFT = 6;

  // Noise source.
  localparam int LFSR_W = 15;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 15'h0001;
  localparam logic [LFSR_W-1:0] NOISE_LO  = 15'd8191;
  localparam logic [LFSR_W-1:0] NOISE_HI  = 15'd24575;
  localparam logic signed [SAMPLE_W-1:0] NOISE_POS = 22'sd1022;
  localparam logic signed [SAMPLE_W-1:0] NOISE_NEG = -22'sd1022;

  // Register map and reset values.
  localparam logic [REG_W-1:0] REG_SAMPLE_RATE = 3'd0;
  localparam logic [REG_W-1:0] REG_FREQ0       = 3'd1;
  localparam logic [REG_W-1:0] REG_OUTPUT_MODE = 3'd7;
  localparam logic [SR_W-1:0]  SR_RESET        = 16'd250;
  localparam logic [NREG_CH-1:0][FREQ_W-1:0] FREQ_RESET =
    {15'd32, 15'd16, 15'd12, 15'd8, 15'd4, 15'd2};
  localparam logic [IDX_W-1:0] IDX_RESET       = 16'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_SINE   = 2'd0,
    MODE_NOISE  = 2'd1,
    MODE_SCALED = 2'd2
  } mode_t;

  localparam logic [MODE_W-1:0] MODE_RESET = MODE_NOISE;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_SINE
  } state_t;

  // Configuration as seen by the datapath; sample_rate is already forced nonzero.
  typedef struct packed {
    logic [SR_W-1:0]                    sample_rate;
    logic [ACTIVE_MAX-1:0][FREQ_W-1:0]  freq;
    logic [MODE_W-1:0]                  mode;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [PHASE_BITS-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic                  start;
    logic [PHASE_BITS-1:0] phase;
  } sine_req_t;

  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] value;
  } sine_rsp_t;

  typedef logic [SINE_W-1:0] sine_rom_t [0:QUARTER];

  // Long division by shift and subtract; used only while the table is built.
  function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 0;
    rem = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      quo = {quo[62:0], 1'b0};
      if (rem >= den) begin
        rem    = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave sine in Q30, a Taylor sum up to the fifteenth power,
  // evaluated once at elaboration.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t       rom;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned dvs;
    for (int unsigned k = 0; k <= QUARTER; k++) begin
      x    = (longint'(k) * HALF_PI_Q30) >> (PHASE_BITS - 2);
      x2   = (x * x) >> Q_SHIFT;
      term = x;
      sum  = x;
      for (int unsigned n = 1; n <= 7; n++) begin
        dvs  = longint'((2 * n) * (2 * n + 1));
        term = div_u64((term * x2) >> Q_SHIFT, dvs);
        if ((n & 1) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      if (sum > ONE_Q30) begin
        sum = ONE_Q30;
      end
      rom[k] = SINE_W'(sum);
    end
    rom[0]       = '0;
    rom[QUARTER] = SINE_W'(ONE_Q30);
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== rtl/core/mcst_in_if.sv =====
// Frame request channel of the multichannel sine test generator.
// Depends on mcst_pkg for the field widths.
interface mcst_in_if import mcst_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] channel_count;
  logic             final_frame;

  modport source (output valid, channel_count, final_frame, input ready);
  modport sink   (input valid, channel_count, final_frame, output ready);

endinterface

// ===== rtl/core/mcst_out_if.sv =====
// Sample result channel of the multichannel sine test generator.
// Depends on mcst_pkg for the field widths.
interface mcst_out_if import mcst_pkg::*; ();

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic [CNT_W-1:0]           channel_index;
  logic                       last_in_frame;
  logic                       buffer_end;

  modport source (output valid, sample_value, channel_index, last_in_frame, buffer_end,
                  input ready);
  modport sink   (input valid, sample_value, channel_index, last_in_frame, buffer_end,
                  output ready);

endinterface

// ===== rtl/core/multichannel_sine_test_generator.sv =====
// Multichannel sine test generator. Each frame request beat produces one sample
// beat per active channel (channel_count, capped at six), in channel order. A
// channel's sample passes through a phase-memory read, an index-times-frequency
// multiply, the loading of the divider, a phase division (twelve steps at four
// quotient bits per cycle, then a done report), and the sine-table lookup and
// scaling. The next request is taken once the last sample of the frame sits in
// the output register. The per-channel phase indices live in a small synchronous
// memory; entries not yet written read as their reset value.
// Depends on mcst_pkg, mcst_in_if, mcst_out_if, mcst_ram, mcst_cfg, mcst_div, mcst_sine.
module multichannel_sine_test_generator import mcst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  mcst_in_if.sink               in_ch,
  mcst_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [REG_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                       cfg;
  div_req_t                   div_req;
  div_rsp_t                   div_rsp;
  sine_req_t                  sine_req;
  sine_rsp_t                  sine_rsp;

  state_t                     state_r;
  state_t                     state_nxt;
  logic [CH_W-1:0]            ch_r;
  logic [CNT_W-1:0]           count_r;
  logic                       final_r;
  logic [ACTIVE_MAX-1:0]      valid_r;
  logic [IDX_W-1:0]           idx_r;
  logic [PROD_W-1:0]          prod_r;
  logic [IDX_W-1:0]           nidx_r;
  logic [IDX_W-1:0]           nidx_nxt;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic [CNT_W-1:0]           out_chan_r;
  logic                       out_last_r;
  logic                       out_end_r;

  logic                       in_rdy;
  logic                       ram_re;
  logic                       ram_we;
  logic                       div_start;
  logic                       sine_start;
  logic                       sine_take;
  logic                       out_load;
  logic                       slot_free;
  logic                       last_c;
  logic [CNT_W-1:0]           count_sat;
  logic [IDX_W-1:0]           ram_rdata;
  logic [IDX_W-1:0]           idx_c;
  logic [FREQ_W-1:0]          freq_c;
  logic [IDX_W-1:0]           idx_inc;
  logic [WRAP_W-1:0]          mul_next;
  logic                       wrap_c;

  // Configuration registers.
  mcst_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Phase index memory, one entry per channel.
  mcst_ram #(
    .WIDTH (IDX_W),
    .DEPTH (ACTIVE_MAX)
  ) u_phase_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ch_r),
    .wdata (nidx_r),
    .re    (ram_re),
    .raddr (ch_r),
    .rdata (ram_rdata)
  );

  // Shared phase divider.
  mcst_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Sine lookup, scaling and noise.
  mcst_sine u_sine (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sine_req),
    .mode  (cfg.mode),
    .take  (sine_take),
    .rsp   (sine_rsp)
  );

  // Frame bookkeeping values.
  always_comb begin
    count_sat = (in_ch.channel_count > CNT_W'(ACTIVE_MAX)) ? CNT_W'(ACTIVE_MAX)
                                                           : in_ch.channel_count;
    last_c    = (CNT_W'(ch_r) + CNT_W'(1)) == count_r;
    slot_free = !out_valid_r || out_ch.ready;
    freq_c    = cfg.freq[ch_r];
    idx_c     = valid_r[ch_r] ? ram_rdata : IDX_RESET;
  end

  // Next index: the index wraps to zero when index+1 equals rate/freq,
  // tested as (index+1)*freq <= rate < (index+2)*freq.
  always_comb begin
    idx_inc  = idx_r + IDX_W'(1);
    mul_next = (idx_r == '1) ? '0 : WRAP_W'(prod_r) + WRAP_W'(freq_c);
    wrap_c   = (mul_next <= WRAP_W'(cfg.sample_rate)) &&
               ((WRAP_W + 1)'(cfg.sample_rate) <
                (WRAP_W + 1)'(mul_next) + (WRAP_W + 1)'(freq_c));
    nidx_nxt = wrap_c ? '0 : idx_inc;
  end

  // Unit requests.
  always_comb begin
    div_req.start    = div_start;
    div_req.dividend = DVD_W'({prod_r, {(PHASE_BITS + 1){1'b0}}}) + DVD_W'(cfg.sample_rate);
    div_req.divisor  = {cfg.sample_rate, 1'b0};
    sine_req.start   = sine_start;
    sine_req.phase   = div_rsp.quotient;
  end

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid && count_sat != '0) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_SINE;
        end
      end
      ST_SINE: begin
        if (sine_rsp.valid && slot_free) begin
          state_nxt = last_c ? ST_IDLE : ST_READ;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_rdy     = 1'b0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    div_start  = 1'b0;
    sine_start = 1'b0;
    sine_take  = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: in_rdy = 1'b1;
      ST_READ: ram_re = 1'b1;
      ST_MUL:  ;
      ST_LOAD: div_start = 1'b1;
      ST_DIV:  sine_start = div_rsp.done;
      ST_SINE: begin
        if (sine_rsp.valid && slot_free) begin
          ram_we    = 1'b1;
          sine_take = 1'b1;
          out_load  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ch_r    <= '0;
      count_r <= '0;
      final_r <= 1'b0;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_ch.valid && in_rdy) begin
        ch_r    <= '0;
        count_r <= count_sat;
        final_r <= in_ch.final_frame;
      end else if (out_load && !last_c) begin
        ch_r <= ch_r + CH_W'(1);
      end
      if (ram_we) begin
        valid_r[ch_r] <= 1'b1;
      end
    end
  end

  // Per-sample datapath registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      idx_r  <= idx_c;
      prod_r <= PROD_W'(idx_c) * PROD_W'(freq_c);
    end
    if (state_r == ST_DIV) begin
      nidx_r <= nidx_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= sine_rsp.value;
      out_chan_r   <= CNT_W'(ch_r);
      out_last_r   <= last_c;
      out_end_r    <= last_c & final_r;
    end
  end

  assign in_ch.ready          = in_rdy;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.sample_value  = out_sample_r;
  assign out_ch.channel_index = out_chan_r;
  assign out_ch.last_in_frame = out_last_r;
  assign out_ch.buffer_end    = out_end_r;

  // The phase memory is never read and written in the same cycle.
  a_ram_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("phase memory read and write collide");

  // The divider only reports completion while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == ST_DIV)
    else $error("divider done outside the divide state");

  // A finished sample is only pending while the sequencer waits to deliver it.
  a_sine_valid: assert property (@(posedge clk) disable iff (!rst_n)
    sine_rsp.valid |-> state_r == ST_SINE)
    else $error("sine result pending outside the deliver state");

  // An accepted nonempty frame starts at channel zero.
  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_rdy && count_sat != '0) |=> (state_r == ST_READ && ch_r == '0))
    else $error("frame did not start at channel zero");

endmodule

// ===== rtl/core/mcst_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module mcst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/mcst_cfg.sv =====
// Configuration register file: sample rate, per-channel frequencies, output mode.
// Depends on mcst_pkg.
module mcst_cfg import mcst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [REG_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic [SR_W-1:0]                   sample_rate_r;
  logic [ACTIVE_MAX-1:0][FREQ_W-1:0] freq_r;
  logic [MODE_W-1:0]                 mode_r;

  // Register writes; frequencies of channels the bank does not build are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_rate_r <= SR_RESET;
      mode_r        <= MODE_RESET;
      for (int i = 0; i < ACTIVE_MAX; i++) begin
        freq_r[i] <= FREQ_RESET[i];
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_SAMPLE_RATE) begin
        sample_rate_r <= cfg_data[SR_W-1:0];
      end
      if (cfg_index == REG_OUTPUT_MODE) begin
        mode_r <= cfg_data[MODE_W-1:0];
      end
      for (int i = 0; i < ACTIVE_MAX; i++) begin
        if (cfg_index == REG_W'(int'(REG_FREQ0) + i)) begin
          freq_r[i] <= cfg_data[FREQ_W-1:0];
        end
      end
    end
  end

  // A zero sample rate is treated as one.
  always_comb begin
    cfg.sample_rate = (sample_rate_r == '0) ? SR_W'(1) : sample_rate_r;
    cfg.freq        = freq_r;
    cfg.mode        = mode_r;
  end

endmodule

// ===== rtl/core/mcst_div.sv =====
// Iterative restoring divider that yields the rounded, wrapped phase of one sample.
// Produces DIV_BITS quotient bits per cycle; depends on mcst_pkg.
module mcst_div import mcst_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [DVD_W-1:0]      dvd_r;
  logic [DSR_W-1:0]      dsr_r;
  logic [DSR_W-1:0]      rem_r;
  logic [PHASE_BITS-1:0] quo_r;
  logic [DSR_W-1:0]      rem_c;
  logic [PHASE_BITS-1:0] quo_c;
  logic [DSR_W:0]        trial;

  // DIV_BITS compare-and-subtract steps; only the low phase bits of the quotient are kept.
  always_comb begin
    rem_c = rem_r;
    quo_c = quo_r;
    trial = '0;
    for (int j = 0; j < DIV_BITS; j++) begin
      trial = {rem_c, dvd_r[DVD_W-1-j]};
      if (trial >= {1'b0, dsr_r}) begin
        rem_c = DSR_W'(trial - {1'b0, dsr_r});
        quo_c = {quo_c[PHASE_BITS-2:0], 1'b1};
      end else begin
        rem_c = trial[DSR_W-1:0];
        quo_c = {quo_c[PHASE_BITS-2:0], 1'b0};
      end
    end
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operand and partial-result registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << DIV_BITS;
      rem_r <= rem_c;
      quo_r <= quo_c;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  // A new division never cuts into one that is still running.
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

endmodule

// ===== rtl/core/mcst_sine.sv =====
// Sine lookup, amplitude scaling, noise and mode shaping of one sample.
// Three-stage pipeline over the constant quarter-wave table; depends on mcst_pkg.
module mcst_sine import mcst_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  sine_req_t         req,
  input  logic [MODE_W-1:0] mode,
  input  logic              take,
  output sine_rsp_t         rsp
);

  logic                        va_r;
  logic                        vb_r;
  logic                        vc_r;
  logic [ROM_AW-1:0]           addr_r;
  logic                        neg_a_r;
  logic                        neg_b_r;
  logic                        neg_c_r;
  logic [SINE_W-1:0]           rom_r;
  logic [MAG_W-1:0]            mag_r;
  logic [LFSR_W-1:0]           lfsr_r;
  logic [ROM_AW-1:0]           addr_c;
  logic [AMP_W-1:0]            amp_c;
  logic [SINE_W+AMP_W-1:0]     scaled_c;
  logic signed [SAMPLE_W-1:0]  mag_s;
  logic signed [SAMPLE_W-1:0]  base_c;
  logic signed [SAMPLE_W-1:0]  noise_c;
  logic signed [SAMPLE_W-1:0]  value_c;

  // Quadrant folding: odd quadrants read the table mirrored.
  always_comb begin
    if (req.phase[PHASE_BITS-2]) begin
      addr_c = ROM_AW'(QUARTER) - ROM_AW'(req.phase[PHASE_BITS-3:0]);
    end else begin
      addr_c = ROM_AW'(req.phase[PHASE_BITS-3:0]);
    end
  end

  // Amplitude by output mode; the unused code behaves as full scale.
  always_comb begin
    unique case (mode)
      MODE_NOISE:  amp_c = AMP_HALF;
      MODE_SCALED: amp_c = AMP_SCALED;
      default:     amp_c = AMP_FULL;
    endcase
    scaled_c = SINE_W'(rom_r) * (SINE_W + AMP_W)'(amp_c);
  end

  // Stage valid flags; the result stays until the sequencer takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= req.start;
      vb_r <= va_r;
      if (vb_r) begin
        vc_r <= 1'b1;
      end else if (take) begin
        vc_r <= 1'b0;
      end
    end
  end

  // Datapath: address, table read, amplitude product.
  always_ff @(posedge clk) begin
    if (req.start) begin
      addr_r  <= addr_c;
      neg_a_r <= req.phase[PHASE_BITS-1];
    end
    if (va_r) begin
      rom_r   <= SINE_ROM[addr_r];
      neg_b_r <= neg_a_r;
    end
    if (vb_r) begin
      mag_r   <= scaled_c[Q_SHIFT+MAG_W-1:Q_SHIFT];
      neg_c_r <= neg_b_r;
    end
  end

  // Three-level noise from the current LFSR state.
  always_comb begin
    priority if (lfsr_r <= NOISE_LO) begin
      noise_c = NOISE_NEG;
    end else if (lfsr_r >= NOISE_HI) begin
      noise_c = NOISE_POS;
    end else begin
      noise_c = '0;
    end
  end

  // Sign, then noise or the scale-by-64 shift.
  always_comb begin
    mag_s  = signed'(SAMPLE_W'(mag_r));
    base_c = neg_c_r ? -mag_s : mag_s;
    unique case (mode)
      MODE_NOISE:  value_c = base_c + noise_c;
      MODE_SCALED: value_c = base_c <<< SCALE_SHIFT;
      default:     value_c = base_c;
    endcase
  end

  // The LFSR steps once per delivered sample in the noise mode only.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= LFSR_SEED;
    end else if (take && mode == MODE_NOISE) begin
      lfsr_r <= {lfsr_r[LFSR_W-2:0], lfsr_r[LFSR_W-1] ^ lfsr_r[LFSR_W-2]};
    end
  end

  assign rsp.valid = vc_r;
  assign rsp.value = value_c;

endmodule
